[design/icc_pkg.sv]
package icc_pkg;

    // Default table depth.
    localparam int MAX_CIRCLES_DEF = 64;

    // Field widths.
    localparam int COORD_W  = 24;
    localparam int RADIUS_W = 23;
    localparam int REGION_W = 8;
    localparam int MARGIN_W = 16;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;

    // Operand width of the shared squarer and width of a squared distance sum.
    localparam int OP_W = 24;
    localparam int SQ_W = 2 * OP_W;
    localparam int D2_W = SQ_W + 1;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(16);

    // Input item kinds.
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_DONE    = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_INSIDE  = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_AMBIG   = 3'd4;

    // One stored circle.
    typedef struct packed {
        logic [REGION_W-1:0]       region;
        logic [RADIUS_W-1:0]       radius;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] cx;
    } circle_t;

    // Query sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SQ_DX,
        ST_SQ_DY,
        ST_SQ_HI,
        ST_SQ_LO,
        ST_SQ_R,
        ST_EVAL
    } state_t;

endpackage

[design/icc_square.sv]
module icc_square
    import icc_pkg::*;
(
    input  logic            clk,
    input  logic [OP_W-1:0] operand,
    output logic [SQ_W-1:0] square
);

    logic [SQ_W-1:0] square_reg;

    // Registered squarer; the product is valid in the cycle after the operand.
    always_ff @(posedge clk)
    begin
        square_reg <= SQ_W'(operand) * SQ_W'(operand);
    end

    assign square = square_reg;

endmodule

[design/innermost_circle_classifier_core.sv]
// Channel    Direction  Handshake                   Payload
// item       in         item_valid / item_stall     kind, region_id, pos_x, pos_y, radius
// result     out        result_valid / result_stall status, found_region
// margin     in         boundary_margin_we          boundary_margin_wdata
//
// Clear, add and unused kinds finish in their transfer cycle; the result shows in the next cycle.
// A query walks each stored circle through read, squaring and evaluation states on one shared
// 24 x 24 squarer; an ambiguous hit ends the walk early and an empty table answers at once.
// Reset clears the circle count and sets the margin to 16. Table entries stay undefined until
// written, and only entries below the count are ever read. A stalled result holds the output
// register, and item_stall stays high until that register can take the next result.
module innermost_circle_classifier_core
    import icc_pkg::*;
#(
    parameter int MAX_CIRCLES = MAX_CIRCLES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       item_valid,
    output logic                       item_stall,
    input  logic [KIND_W-1:0]          kind,
    input  logic [REGION_W-1:0]        region_id,
    input  logic signed [COORD_W-1:0]  pos_x,
    input  logic signed [COORD_W-1:0]  pos_y,
    input  logic [RADIUS_W-1:0]        radius,

    output logic                       result_valid,
    input  logic                       result_stall,
    output logic [STATUS_W-1:0]        status,
    output logic [REGION_W-1:0]        found_region,

    input  logic                       boundary_margin_we,
    input  logic [MARGIN_W-1:0]        boundary_margin_wdata
);

    // The count must hold the depth itself; the index only addresses entries.
    localparam int CNT_W = $clog2(MAX_CIRCLES + 1);
    localparam int IDX_W = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;

    // Circle table, written on add and read one entry at a time by a query.
    circle_t mem [MAX_CIRCLES];
    circle_t rd_reg;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]          count_reg, count_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [MARGIN_W-1:0]       margin_reg;
    logic signed [COORD_W-1:0] px_reg, px_next;
    logic signed [COORD_W-1:0] py_reg, py_next;

    logic [D2_W-1:0]           d2_reg, d2_next;
    logic                      hi_ok_reg, hi_ok_next;
    logic                      lo_ok_reg, lo_ok_next;
    logic                      have_reg, have_next;
    logic [RADIUS_W-1:0]       best_r_reg, best_r_next;
    logic [REGION_W-1:0]       best_reg_reg, best_reg_next;

    // Result waiting for the output register after a query walk.
    logic                      pend_reg, pend_next;
    logic [STATUS_W-1:0]       pend_status_reg, pend_status_next;
    logic [REGION_W-1:0]       pend_region_reg, pend_region_next;

    logic                      out_valid_reg;
    logic [STATUS_W-1:0]       out_status_reg;
    logic [REGION_W-1:0]       out_region_reg;

    logic                      out_free;
    logic                      out_load;
    logic [STATUS_W-1:0]       out_status_d;
    logic [REGION_W-1:0]       out_region_d;
    logic                      accept;
    logic                      mem_we;
    logic                      mem_re;

    logic [OP_W-1:0]           sq_operand;
    logic [SQ_W-1:0]           sq_result;

    logic signed [COORD_W:0]   diff_x, diff_y;
    logic [OP_W-1:0]           abs_x, abs_y;
    logic [CNT_W-1:0]          idx_plus;

    icc_square u_square
    (
        .clk     (clk),
        .operand (sq_operand),
        .square  (sq_result)
    );

    // Absolute coordinate differences against the fetched circle. The magnitude
    // never exceeds 2^24 - 1, so it fits the squarer operand.
    always_comb
    begin
        diff_x = {px_reg[COORD_W-1], px_reg} - {rd_reg.cx[COORD_W-1], rd_reg.cx};
        diff_y = {py_reg[COORD_W-1], py_reg} - {rd_reg.cy[COORD_W-1], rd_reg.cy};
        abs_x  = diff_x[COORD_W] ? OP_W'(-diff_x) : OP_W'(diff_x);
        abs_y  = diff_y[COORD_W] ? OP_W'(-diff_y) : OP_W'(diff_y);
    end

    assign out_free     = !out_valid_reg || !result_stall;
    assign item_stall   = (state_reg != ST_IDLE) || pend_reg || !out_free;
    assign accept       = item_valid && !item_stall;
    assign idx_plus     = CNT_W'(idx_reg) + CNT_W'(1);

    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign found_region = out_region_reg;

    // Sequencer. Each circle goes through read, five squarings and an
    // evaluation; the squarer output always belongs to the previous state.
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        px_next          = px_reg;
        py_next          = py_reg;
        d2_next          = d2_reg;
        hi_ok_next       = hi_ok_reg;
        lo_ok_next       = lo_ok_reg;
        have_next        = have_reg;
        best_r_next      = best_r_reg;
        best_reg_next    = best_reg_reg;
        pend_next        = pend_reg;
        pend_status_next = pend_status_reg;
        pend_region_next = pend_region_reg;
        out_load         = 1'b0;
        out_status_d     = STATUS_DONE;
        out_region_d     = '0;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        sq_operand       = abs_x;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pend_reg && out_free)
                begin
                    out_load     = 1'b1;
                    out_status_d = pend_status_reg;
                    out_region_d = pend_region_reg;
                    pend_next    = 1'b0;
                end
                else if (accept)
                begin
                    out_load = 1'b1;
                    unique case (kind)
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                        end
                        KIND_ADD:
                        begin
                            if (count_reg >= CNT_W'(MAX_CIRCLES))
                            begin
                                out_status_d = STATUS_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        KIND_QUERY:
                        begin
                            px_next   = pos_x;
                            py_next   = pos_y;
                            have_next = 1'b0;
                            idx_next  = '0;
                            if (count_reg == '0)
                            begin
                                out_status_d = STATUS_OUTSIDE;
                            end
                            else
                            begin
                                out_load   = 1'b0;
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            out_status_d = STATUS_DONE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                mem_re     = 1'b1;
                state_next = ST_SQ_DX;
            end
            ST_SQ_DX:
            begin
                sq_operand = abs_x;
                state_next = ST_SQ_DY;
            end
            ST_SQ_DY:
            begin
                sq_operand = abs_y;
                d2_next    = D2_W'(sq_result);
                state_next = ST_SQ_HI;
            end
            ST_SQ_HI:
            begin
                sq_operand = OP_W'(rd_reg.radius) + OP_W'(margin_reg);
                d2_next    = d2_reg + D2_W'(sq_result);
                state_next = ST_SQ_LO;
            end
            ST_SQ_LO:
            begin
                // When the radius is below the margin this wraps; the lower
                // bound is then ignored.
                sq_operand = OP_W'(rd_reg.radius) - OP_W'(margin_reg);
                hi_ok_next = d2_reg < D2_W'(sq_result);
                state_next = ST_SQ_R;
            end
            ST_SQ_R:
            begin
                sq_operand = OP_W'(rd_reg.radius);
                lo_ok_next = (RADIUS_W'(margin_reg) > rd_reg.radius
                              && MARGIN_W'(rd_reg.radius) < margin_reg)
                             || (OP_W'(rd_reg.radius) < OP_W'(margin_reg))
                             || (d2_reg > D2_W'(sq_result));
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (hi_ok_reg && lo_ok_reg)
                begin
                    // Point sits in the boundary band: the walk stops here.
                    pend_next        = 1'b1;
                    pend_status_next = STATUS_AMBIG;
                    pend_region_next = rd_reg.region;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    if ((d2_reg < D2_W'(sq_result))
                        && (!have_reg || (rd_reg.radius < best_r_reg)))
                    begin
                        have_next     = 1'b1;
                        best_r_next   = rd_reg.radius;
                        best_reg_next = rd_reg.region;
                    end
                    if (idx_plus == count_reg)
                    begin
                        pend_next = 1'b1;
                        if ((d2_reg < D2_W'(sq_result)) || have_reg)
                        begin
                            pend_status_next = STATUS_INSIDE;
                            pend_region_next =
                                ((d2_reg < D2_W'(sq_result))
                                 && (!have_reg || (rd_reg.radius < best_r_reg)))
                                ? rd_reg.region : best_reg_reg;
                        end
                        else
                        begin
                            pend_status_next = STATUS_OUTSIDE;
                            pend_region_next = '0;
                        end
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = IDX_W'(idx_plus);
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            margin_reg    <= MARGIN_RESET;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            have_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            have_reg      <= have_next;
            out_valid_reg <= out_load || (out_valid_reg && result_stall);
            if (boundary_margin_we)
            begin
                margin_reg <= boundary_margin_wdata;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        px_reg          <= px_next;
        py_reg          <= py_next;
        d2_reg          <= d2_next;
        hi_ok_reg       <= hi_ok_next;
        lo_ok_reg       <= lo_ok_next;
        best_r_reg      <= best_r_next;
        best_reg_reg    <= best_reg_next;
        pend_status_reg <= pend_status_next;
        pend_region_reg <= pend_region_next;
        if (out_load)
        begin
            out_status_reg <= out_status_d;
            out_region_reg <= out_region_d;
        end
    end

    // Circle table: one write port for adds, one registered read port for queries.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[IDX_W-1:0]] <= '{region: region_id, radius: radius,
                                           cy: pos_y, cx: pos_x};
        end
        if (mem_re)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

endmodule

[tb/sv/innermost_circle_classifier_core_test.sv]
`timescale 1ns / 1ps

// Self-checking bench for the circle classifier core. Items go in over a valid/stall
// channel, and each one produces exactly one result transfer. A predictor in this file
// keeps its own copy of the circle table and the margin register. It works out the
// status and region of every item at the moment the item's transfer is accepted. The
// receiver process compares each result transfer, field by field, against the oldest
// value waiting in the queue.
module innermost_circle_classifier_core_test;
    import icc_pkg::*;

    localparam int CLK_HALF_NS   = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int TABLE_DEPTH   = MAX_CIRCLES_DEF;
    localparam int SEGMENTS      = 6;
    localparam int SEGMENT_ITEMS = 150;
    localparam int HOLD_CYCLES   = 400;
    localparam int REPORT_LIMIT  = 10;
    // A full-table query walks every stored circle in turn. These bounds allow for that
    // and for a receiver that stalls a lot.
    localparam int DRAIN_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 500;
    // Several times the slowest legal run: about 1000 items, each one a full-table query
    // that also waits out receiver stalls.
    localparam int TIMEOUT_NS    = 40_000_000;

    // The unused kind. The core must answer it with a plain done.
    localparam logic [KIND_W-1:0]   KIND_SPARE = 2'd3;
    localparam logic [MARGIN_W-1:0] MARGIN_MIN = '0;
    localparam logic [MARGIN_W-1:0] MARGIN_MAX = '1;

    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic [REGION_W-1:0]        region;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic [RADIUS_W-1:0]        r;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [REGION_W-1:0] region;
    } verdict_t;

    // In a directed row, pinned means that the answer is obvious from the row alone.
    // That answer is typed in and used as the expected result. Every other row takes the
    // predictor's answer.
    typedef struct packed {
        item_t    stim;
        logic     pinned;
        verdict_t answer;
    } dir_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       item_valid = 1'b0;
    logic                       item_stall;
    logic [KIND_W-1:0]          kind = KIND_CLEAR;
    logic [REGION_W-1:0]        region_id = '0;
    logic signed [COORD_W-1:0]  pos_x = '0;
    logic signed [COORD_W-1:0]  pos_y = '0;
    logic [RADIUS_W-1:0]        radius = '0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    logic [STATUS_W-1:0]        status;
    logic [REGION_W-1:0]        found_region;
    logic                       boundary_margin_we = 1'b0;
    logic [MARGIN_W-1:0]        boundary_margin_wdata = '0;

    innermost_circle_classifier_core u_top (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .item_valid            (item_valid),
        .item_stall            (item_stall),
        .kind                  (kind),
        .region_id             (region_id),
        .pos_x                 (pos_x),
        .pos_y                 (pos_y),
        .radius                (radius),
        .result_valid          (result_valid),
        .result_stall          (result_stall),
        .status                (status),
        .found_region          (found_region),
        .boundary_margin_we    (boundary_margin_we),
        .boundary_margin_wdata (boundary_margin_wdata)
    );

    always #CLK_HALF_NS clk = ~clk;

    // The predictor's copy of the circle table and of the margin register.
    logic signed [COORD_W-1:0] circle_x      [TABLE_DEPTH];
    logic signed [COORD_W-1:0] circle_y      [TABLE_DEPTH];
    logic [RADIUS_W-1:0]       circle_r      [TABLE_DEPTH];
    logic [REGION_W-1:0]       circle_region [TABLE_DEPTH];
    int                        stored_circles = 0;
    longint                    margin_now = MARGIN_RESET;

    verdict_t awaited_results [$];

    // Percent of cycles in which each side idles. These values change only between
    // phases, while the core has no work.
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_go = 1'b0;
    logic        hold_active = 1'b0;

    int items_sent = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int margin_writes = 0;
    int input_stall_cycles = 0;
    int status_tally [8];

    // The directed rows all run with the margin at its reset value, 16. The first circles
    // are three concentric ones. The first is as large as possible. The other two share
    // one radius, so the first of that pair must win. The queries then probe the center,
    // the exact boundary, the two bounds of the margin band, and the corners of the
    // coordinate range.
    dir_row_t directed_rows [21] = '{
        '{'{KIND_QUERY, 8'h00, 24'h000000, 24'h000000, 23'h000000}, 1'b1,
          '{STATUS_OUTSIDE, 8'h00}},
        '{'{KIND_SPARE, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 23'h7FFFFF}, 1'b1,
          '{STATUS_DONE, 8'h00}},
        '{'{KIND_ADD,   8'h11, 24'h000000, 24'h000000, 23'h7FFFFF}, 1'b1,
          '{STATUS_DONE, 8'h00}},
        '{'{KIND_ADD,   8'h22, 24'h000000, 24'h000000, 23'h001000}, 1'b1,
          '{STATUS_DONE, 8'h00}},
        '{'{KIND_ADD,   8'h33, 24'h000000, 24'h000000, 23'h001000}, 1'b1,
          '{STATUS_DONE, 8'h00}},
        '{'{KIND_QUERY, 8'h00, 24'h000000, 24'h000000, 23'h000000}, 1'b0, '0},
        '{'{KIND_QUERY, 8'h00, 24'h001000, 24'h000000, 23'h000000}, 1'b0, '0},
        '{'{KIND_QUERY, 8'h00, 24'h001010, 24'h000000, 23'h000000}, 1'b0, '0},
        '{'{KIND_QUERY, 8'h00, 24'h000FF0, 24'h000000, 23'h000000}, 1'b0, '0},
        '{'{KIND_QUERY, 8'h00, 24'h000000, 24'hFFEFF1, 23'h000000}, 1'b0, '0},
        '{'{KIND_QUERY, 8'h00, 24'h7FFFFF, 24'h000000, 23'h000000}, 1'b0, '0},
        '{'{KIND_QUERY, 8'h00, 24'h800000, 24'h800000, 23'h000000}, 1'b0, '0},
        // A circle with zero radius is smaller than the margin, so the band has no hole.
        '{'{KIND_ADD,   8'h44, 24'h000100, 24'h000100, 23'h000000}, 1'b1,
          '{STATUS_DONE, 8'h00}},
        '{'{KIND_QUERY, 8'h00, 24'h000100, 24'h000100, 23'h000000}, 1'b0, '0},
        '{'{KIND_ADD,   8'h00, 24'h7FFFFF, 24'h800000, 23'h000000}, 1'b1,
          '{STATUS_DONE, 8'h00}},
        '{'{KIND_QUERY, 8'h00, 24'h7FFFFF, 24'h800000, 23'h000000}, 1'b0, '0},
        '{'{KIND_CLEAR, 8'h00, 24'h000000, 24'h000000, 23'h000000}, 1'b1,
          '{STATUS_DONE, 8'h00}},
        '{'{KIND_QUERY, 8'h00, 24'h000000, 24'h000000, 23'h000000}, 1'b1,
          '{STATUS_OUTSIDE, 8'h00}},
        '{'{KIND_ADD,   8'hFF, 24'h800000, 24'h7FFFFF, 23'h7FFFFF}, 1'b1,
          '{STATUS_DONE, 8'h00}},
        '{'{KIND_QUERY, 8'h00, 24'h000000, 24'h000000, 23'h000000}, 1'b0, '0},
        '{'{KIND_CLEAR, 8'h00, 24'h000000, 24'h000000, 23'h000000}, 1'b1,
          '{STATUS_DONE, 8'h00}}
    };

    // Works out the result of one item and applies the item to the predictor's table.
    // All distances are squared and held in 64 bits. The walk stops at the first circle
    // whose margin band holds the point. Apart from that case, only a strictly smaller
    // radius replaces the innermost circle found so far.
    function automatic verdict_t classify_item(input item_t it);
        verdict_t v;
        longint   px, py, dx, dy, d2, rr, best_r;
        bit       have, edge_hit, low_ok;
        v.status = STATUS_DONE;
        v.region = '0;
        if (it.kind == KIND_CLEAR)
        begin
            stored_circles = 0;
        end
        else if (it.kind == KIND_ADD)
        begin
            if (stored_circles >= TABLE_DEPTH)
            begin
                v.status = STATUS_FULL;
            end
            else
            begin
                circle_x[stored_circles]      = it.x;
                circle_y[stored_circles]      = it.y;
                circle_r[stored_circles]      = it.r;
                circle_region[stored_circles] = it.region;
                stored_circles++;
            end
        end
        else if (it.kind == KIND_QUERY)
        begin
            px = $signed(it.x);
            py = $signed(it.y);
            v.status = STATUS_OUTSIDE;
            have = 1'b0;
            edge_hit = 1'b0;
            best_r = 0;
            for (int i = 0; i < stored_circles && !edge_hit; i++)
            begin
                dx = px - circle_x[i];
                dy = py - circle_y[i];
                d2 = dx * dx + dy * dy;
                rr = circle_r[i];
                low_ok = (rr < margin_now) ||
                         (d2 > (rr - margin_now) * (rr - margin_now));
                if (d2 < (rr + margin_now) * (rr + margin_now) && low_ok)
                begin
                    v.status = STATUS_AMBIG;
                    v.region = circle_region[i];
                    edge_hit = 1'b1;
                end
                else if (d2 < rr * rr && (!have || rr < best_r))
                begin
                    have = 1'b1;
                    best_r = rr;
                    v.region = circle_region[i];
                end
            end
            if (!edge_hit && have)
                v.status = STATUS_INSIDE;
        end
        return v;
    endfunction

    function automatic longint signed_span(input longint reach);
        return longint'($urandom_range(0, 2 * reach)) - reach;
    endfunction

    // Offers one item and holds the payload steady until the transfer is taken. The
    // expected result is queued at the edge that accepts the transfer, so queue order
    // always follows transfer order. At that same edge valid is left high. The next call
    // either keeps valid high or lowers it, and so there is never more than one update
    // of valid per edge.
    task automatic send_item(input item_t it, input bit pinned, input verdict_t pin);
        verdict_t predicted;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        kind       <= it.kind;
        region_id  <= it.region;
        pos_x      <= it.x;
        pos_y      <= it.y;
        radius     <= it.r;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predicted = classify_item(it);
        awaited_results.push_back(pinned ? pin : predicted);
        if (it.kind != KIND_SPARE)
            items_sent++;
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_margin(input logic [MARGIN_W-1:0] value);
        @(posedge clk);
        boundary_margin_we    <= 1'b1;
        boundary_margin_wdata <= value;
        @(posedge clk);
        boundary_margin_we    <= 1'b0;
        margin_now = value;
        margin_writes++;
    endtask

    // A sequence either sends one item of noise or follows a fixed pattern with random
    // content. The pattern usually starts with a clear. It then adds a cluster of circles
    // and runs queries aimed at the stored circles. Each query lands on one of these
    // places: the exact boundary, somewhere in the margin band, inside the circle, the
    // center, a diagonal near the boundary, or a random point. Most tables stay small so
    // that the walks stay short. Now and then a table is filled past its depth, so that
    // the dropped-add status and the longest walks both get exercised.
    task automatic run_sequence(input bit fill_table);
        item_t  it;
        int     n_add, n_query, j, pick;
        longint base_x, base_y, off_x, off_y, rad, prev_r, band, swap_tmp;
        if (!fill_table && $urandom_range(99) < 12)
        begin
            it.kind   = KIND_W'($urandom_range(0, 3));
            it.region = REGION_W'($urandom);
            it.x      = COORD_W'($urandom);
            it.y      = COORD_W'($urandom);
            it.r      = RADIUS_W'($urandom);
            send_item(it, 1'b0, '0);
            return;
        end
        it = '0;
        if (fill_table || $urandom_range(99) < 80)
        begin
            it.kind = KIND_CLEAR;
            send_item(it, 1'b0, '0);
        end
        pick = $urandom_range(99);
        if (fill_table)
            n_add = TABLE_DEPTH + 2;
        else if (pick < 70)
            n_add = $urandom_range(1, 6);
        else if (pick < 96)
            n_add = $urandom_range(7, 20);
        else
            n_add = $urandom_range(TABLE_DEPTH - 2, TABLE_DEPTH + 2);
        if ($urandom_range(9) == 0)
        begin
            base_x = signed_span(8388608);
            base_y = signed_span(8388608);
        end
        else
        begin
            base_x = signed_span(2097152);
            base_y = signed_span(2097152);
        end
        prev_r = $urandom_range(0, 4096);
        for (int k = 0; k < n_add; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
                rad = prev_r;
            else if (pick < 65)
                rad = $urandom_range(0, 4096);
            else if (pick < 92)
                rad = $urandom_range(0, 262143);
            else
                rad = $urandom_range(0, 8388607);
            prev_r = rad;
            // About a quarter of the circles share the cluster center, so they nest.
            off_x = $urandom_range(1) ? signed_span(512) : 0;
            off_y = $urandom_range(1) ? signed_span(512) : 0;
            it.kind   = KIND_ADD;
            it.region = REGION_W'($urandom);
            it.x      = COORD_W'(base_x + off_x);
            it.y      = COORD_W'(base_y + off_y);
            it.r      = RADIUS_W'(rad);
            send_item(it, 1'b0, '0);
        end
        n_query = fill_table ? 4 : $urandom_range(2, 7);
        for (int k = 0; k < n_query; k++)
        begin
            it.kind   = KIND_QUERY;
            it.region = REGION_W'($urandom);
            it.r      = RADIUS_W'($urandom);
            pick = $urandom_range(0, 5);
            if (stored_circles == 0 || pick == 4)
            begin
                it.x = COORD_W'($urandom);
                it.y = COORD_W'($urandom);
            end
            else
            begin
                j = $urandom_range(0, stored_circles - 1);
                rad = circle_r[j];
                band = margin_now + 2;
                off_y = 0;
                case (pick)
                    0: off_x = rad;
                    1: off_x = rad + signed_span(band);
                    2: off_x = $urandom_range(0, rad);
                    3: off_x = 0;
                    default:
                    begin
                        // 181/256 is close to 1/sqrt(2), which places the point near
                        // the boundary on a diagonal.
                        off_x = (rad * 181) / 256 + signed_span(band);
                        off_y = (rad * 181) / 256 + signed_span(band);
                    end
                endcase
                if ($urandom_range(1))
                begin
                    swap_tmp = off_x;
                    off_x = off_y;
                    off_y = swap_tmp;
                end
                if ($urandom_range(1))
                    off_x = -off_x;
                if ($urandom_range(1))
                    off_y = -off_y;
                it.x = COORD_W'(longint'(circle_x[j]) + off_x);
                it.y = COORD_W'(longint'(circle_y[j]) + off_y);
            end
            send_item(it, 1'b0, '0);
        end
    endtask

    // The receiver. A result transfer happens at an edge where valid is high and stall is
    // low. Both signals are sampled before the edge takes effect. The stall level for the
    // next cycle is then picked at random, unless the long hold-off is running.
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && item_valid && item_stall)
            input_stall_cycles++;
        if (rst_n && result_valid && !result_stall)
        begin
            results_checked++;
            if (status < 8)
                status_tally[status]++;
            if (awaited_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: expected none, got status %0d region 0x%02h",
                             status, found_region);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (status !== want.status)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("status mismatch: expected %0d, got %0d",
                                 want.status, status);
                end
                if (found_region !== want.region)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("region mismatch: expected 0x%02h, got 0x%02h (status %0d)",
                                 want.region, found_region, want.status);
                end
            end
        end
        result_stall <= hold_active || ($urandom_range(99) < recv_idle_pct);
    end

    // The long hold-off. The receiver takes nothing while it lasts, and
    // the sender keeps offering items. The output register fills, and the core then has
    // to stall its input.
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES)
            @(posedge clk);
        hold_active <= 1'b0;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        logic [MARGIN_W-1:0] margin_plan [SEGMENTS];
        int                  seg_start;
        int                  directed_items;
        int                  drain_cycles;
        foreach (status_tally[s])
            status_tally[s] = 0;

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The directed part runs with the margin left at its reset value.
        send_idle_pct = 35;
        recv_idle_pct = 49;
        foreach (directed_rows[n])
            send_item(directed_rows[n].stim, directed_rows[n].pinned,
                      directed_rows[n].answer);
        directed_items = items_sent;

        // The random part runs in phases with their own margins; pairs share an idle pattern.
        // Both extremes of the margin are covered, and so is a write of the reset value.
        margin_plan[0] = MARGIN_MIN;
        margin_plan[1] = MARGIN_MAX;
        margin_plan[2] = MARGIN_W'($urandom_range(0, 65535));
        margin_plan[3] = MARGIN_W'(1);
        margin_plan[4] = MARGIN_RESET;
        margin_plan[5] = MARGIN_W'($urandom_range(0, 255));
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_idle();
            write_margin(margin_plan[seg]);
            send_idle_pct = (seg < 2) ? 35 : (seg < 4) ? 49 : 0;
            recv_idle_pct = (seg < 2) ? 49 : (seg < 4) ? 35 : 0;
            if (seg == 2)
                hold_go = 1'b1;
            seg_start = items_sent;
            run_sequence(seg == 0);
            while (items_sent - seg_start < SEGMENT_ITEMS)
                run_sequence(1'b0);
        end

        item_valid <= 1'b0;
        drain_cycles = 0;
        while (awaited_results.size() != 0 && drain_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_cycles++;
        end
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        if (awaited_results.size() != 0)
        begin
            $display("%0d expected results never arrived", awaited_results.size());
            mismatch_count += awaited_results.size();
        end
        $display("Covered %0d items (%0d directed), %0d results, %0d margin writes, %0d-cycle hold.",
                 items_sent, directed_items, results_checked, margin_writes, HOLD_CYCLES);
        $display("Seen: inside %0d, outside %0d, ambiguous %0d, dropped %0d; input stalled %0d cycles.",
                 status_tally[STATUS_INSIDE], status_tally[STATUS_OUTSIDE],
                 status_tally[STATUS_AMBIG], status_tally[STATUS_FULL], input_stall_cycles);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
design/icc_pkg.sv
design/icc_square.sv
design/innermost_circle_classifier_core.sv
tb/sv/innermost_circle_classifier_core_test.sv
